[sv/pcx_rle_encoder_unit_assert.svh]
// assertion macros for the pcx run-length encoder
`ifndef PCX_RLE_ENCODER_UNIT_ASSERT_SVH
`define PCX_RLE_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCX_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pcx rle encoder assertion failed");
// next-cycle implication
`define PCX_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pcx rle encoder assertion failed");
`else
`define PCX_ASSERT_SAME(label, ck, rn, ante, cons)
`define PCX_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

[sv/pcx_rle_pkg.sv]
// shared types, constants and descriptor helpers for the pcx run-length encoder
package pcx_rle_pkg;

    localparam logic [7:0] RLE_MARK      = 8'd192;
    localparam logic [7:0] HIGH_CODE     = 8'd193;
    localparam logic [7:0] RUN_FULL_CODE = 8'd254;
    localparam logic [5:0] LAST_PENDING  = 6'd62;
    localparam int         MAX_BYTES     = 5;
    localparam logic [1:0] QUEUE_DEPTH   = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } pix_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } code_t;

    // coded bytes caused by one item, in order from index 0
    typedef struct packed {
        logic [2:0]                 count;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } desc_t;

    typedef struct packed {
        logic [1:0] level;
        logic       full;
        logic       empty;
    } qstat_t;

    function automatic desc_t desc_push(desc_t d, logic [7:0] b);
        desc_t r;
        r = d;
        r.bytes[d.count] = b;
        r.count = d.count + 3'd1;
        return r;
    endfunction

    // emit a pending run of c copies of v
    function automatic desc_t desc_flush(desc_t d, logic [7:0] v, logic [5:0] c);
        desc_t r;
        r = d;
        if (c > 6'd1)
        begin
            r = desc_push(r, RLE_MARK | {2'b00, c - 6'd1});
            r = desc_push(r, v);
        end
        if (c != 6'd0)
        begin
            r = desc_push(r, v);
        end
        return r;
    endfunction

endpackage

[sv/pcx_rle_encoder_unit.sv]
// top level of the pcx run-length encoder: front, descriptor queue, back
// an accepted item is written to the queue, then loaded into the back end to be sent
// throughput: one pixel per cycle while the descriptor queue has room; the back
//   end sends one coded byte per cycle while code_ready is high, so an item causing
//   k bytes (0..5) holds the output port for k transfers; that port sets the rate
// reset: rst_n low clears the run state, the queue and the output stage at once
`include "pcx_rle_encoder_unit_assert.svh"

module pcx_rle_encoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  pcx_rle_pkg::pix_t  pix,
    output logic               code_valid,
    input  logic               code_ready,
    output pcx_rle_pkg::code_t code
);

    // front to queue
    logic                push;
    pcx_rle_pkg::desc_t  push_desc;

    // queue to back, status shared by both sides
    logic                pop;
    pcx_rle_pkg::desc_t  head_desc;
    pcx_rle_pkg::qstat_t q_stat;

    // front: keeps held value and pending count, codes each item into a
    // descriptor holding up to five bytes; stalls only when the queue is full
    pcx_rle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .q_stat    (q_stat),
        .push      (push),
        .push_desc (push_desc)
    );

    // queue: absorbs bursts so pixels keep flowing while bytes drain
    pcx_rle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .q_stat    (q_stat)
    );

    // back: walks the current descriptor one byte per cycle while code_ready is high,
    // loading the next one from the queue on the same edge the final byte is taken, so there is no bubble
    pcx_rle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head_desc  (head_desc),
        .pop        (pop),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

    // a stored descriptor always carries one to five bytes
    `PCX_ASSERT_SAME(a_desc_count, clk, rst_n, push,
        (push_desc.count != 3'd0) && (push_desc.count <= 3'd5))

    // a full queue must hold off the pixel side
    `PCX_ASSERT_SAME(a_full_stalls, clk, rst_n, q_stat.full, !pix_ready)

    // final byte taken with nothing queued leaves the output empty
    `PCX_ASSERT_NEXT(a_drain_idle, clk, rst_n,
        code_valid && code_ready && code.last_of_run && q_stat.empty, !code_valid)

endmodule

[sv/pcx_rle_front.sv]
// front end: run tracking and coding of one item into a byte descriptor
module pcx_rle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  pcx_rle_pkg::pix_t   pix,
    input  pcx_rle_pkg::qstat_t q_stat,
    output logic                push,
    output pcx_rle_pkg::desc_t  push_desc
);

    logic [7:0] held_reg, held_next;
    logic [5:0] count_reg, count_next;
    logic       accept;

    assign pix_ready = !q_stat.full;
    assign accept    = pix_valid && pix_ready;

    always_comb
    begin
        pcx_rle_pkg::desc_t d;
        logic [7:0] h;
        logic [5:0] c;
        d = '0;
        h = held_reg;
        c = count_reg;
        if (pix.pixel >= pcx_rle_pkg::RLE_MARK)
        begin
            // high pixel: flush, then literal pair
            d = pcx_rle_pkg::desc_flush(d, h, c);
            d = pcx_rle_pkg::desc_push(d, pcx_rle_pkg::HIGH_CODE);
            d = pcx_rle_pkg::desc_push(d, pix.pixel);
            c = 6'd0;
        end
        else if (c != 6'd0 && pix.pixel == h)
        begin
            if (c == pcx_rle_pkg::LAST_PENDING)
            begin
                d = pcx_rle_pkg::desc_push(d, pcx_rle_pkg::RUN_FULL_CODE);
                d = pcx_rle_pkg::desc_push(d, h);
                c = 6'd1;
            end
            else
            begin
                c = c + 6'd1;
            end
        end
        else
        begin
            d = pcx_rle_pkg::desc_flush(d, h, c);
            h = pix.pixel;
            c = 6'd1;
        end
        if (pix.last_pixel)
        begin
            d = pcx_rle_pkg::desc_flush(d, h, c);
            c = 6'd0;
        end
        push_desc  = d;
        held_next  = h;
        count_next = c;
    end

    // items that cause no byte leave nothing in the queue
    assign push = accept && (push_desc.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 8'd0;
            count_reg <= 6'd0;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

[sv/pcx_rle_queue.sv]
// two-entry descriptor queue between front and back
module pcx_rle_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcx_rle_pkg::desc_t  push_desc,
    input  logic                pop,
    output pcx_rle_pkg::desc_t  head_desc,
    output pcx_rle_pkg::qstat_t q_stat
);

    pcx_rle_pkg::desc_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;

    assign head_desc    = entry_reg[rd_ptr_reg];
    assign q_stat.level = level_reg;
    assign q_stat.full  = (level_reg == pcx_rle_pkg::QUEUE_DEPTH);
    assign q_stat.empty = (level_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

[sv/pcx_rle_back.sv]
// back end: serializes descriptors into coded bytes, one per cycle while code_ready is high
module pcx_rle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pcx_rle_pkg::qstat_t q_stat,
    input  pcx_rle_pkg::desc_t  head_desc,
    output logic                pop,
    output logic                code_valid,
    input  logic                code_ready,
    output pcx_rle_pkg::code_t  code
);

    pcx_rle_pkg::desc_t cur_reg;
    logic       busy_reg, busy_next;
    logic [2:0] pos_reg, pos_next;
    logic       last_byte;
    logic       fire;

    assign last_byte = (pos_reg == cur_reg.count - 3'd1);
    assign fire      = busy_reg && code_ready;
    assign pop       = !q_stat.empty && (!busy_reg || (fire && last_byte));

    assign code_valid       = busy_reg;
    assign code.out_byte    = cur_reg.bytes[pos_reg];
    assign code.last_of_run = last_byte;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            pos_next  = 3'd0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

endmodule
